>>> src/line_pixel_generator_top_assert.svh
// Assertion macros shared by the line pixel generator RTL.
`ifndef LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line pixel generator check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line pixel generator check failed");

`endif

>>> src/lpg_pkg.sv
// Package with the request codes and payload layouts of the line pixel generator.
package lpg_pkg;

    localparam int unsigned X_WIDTH     = 9;
    localparam int unsigned Y_WIDTH     = 8;
    localparam int unsigned COLOR_WIDTH = 16;
    localparam int unsigned ADDR_WIDTH  = 32;

    localparam logic [ADDR_WIDTH-1:0] BASE_RESET = 32'hC800_0000;

    typedef enum logic
    {
        OP_START = 1'b0,
        OP_NEXT  = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [5:0]             pad;
        logic [COLOR_WIDTH-1:0] stroke_color;
        logic [Y_WIDTH-1:0]     y_second;
        logic [X_WIDTH-1:0]     x_second;
        logic [Y_WIDTH-1:0]     y_first;
        logic [X_WIDTH-1:0]     x_first;
    } in_data_t;

    typedef struct packed
    {
        logic [6:0]             pad;
        logic [COLOR_WIDTH-1:0] pixel_color;
        logic [ADDR_WIDTH-1:0]  pixel_address;
        logic [Y_WIDTH-1:0]     pixel_y;
        logic [X_WIDTH-1:0]     pixel_x;
    } out_data_t;

endpackage

>>> src/line_pixel_generator_top.sv
// Line pixel generator: steps a line between two endpoints and emits one pixel per request.
//
// A start request (tuser 0) loads both endpoints and the color from s_axis_tdata and
// produces the first pixel of the line; each next request (tuser 1) produces the
// following pixel. A next request while no line is running produces a result with
// tuser 0 and all data zero. Each result carries x, y, color and the frame buffer
// address buffer_base + (y << ROW_SHIFT) + (x << PIXEL_SHIFT); tlast marks the final
// pixel. buffer_base is loaded through the cfg channel, which is always ready.
// From an accepted request, the middle stage registers the stepped line state and the
// output stage registers the coordinates and the address formed from it. Throughput
// is one request per cycle while the result is not stalled, set by the single
// remainder add, compare and subtract that advances the minor coordinate. When the
// receiver stalls, the result holds and one more request can be taken into the middle
// stage before s_axis_tready falls. Reset clears the line state and the control bits
// of both stages, but not the output data, and loads buffer_base with 0xC8000000.
module line_pixel_generator_top #(
    parameter int unsigned ROW_SHIFT   = 10,
    parameter int unsigned PIXEL_SHIFT = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // x_first[8:0], y_first[16:9], x_second[25:17], y_second[33:26], stroke_color[49:34]
    input  lpg_pkg::in_data_t    s_axis_tdata,
    // operation[0]
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // pixel_x[8:0], pixel_y[16:9], pixel_address[48:17], pixel_color[64:49]
    output lpg_pkg::out_data_t   m_axis_tdata,
    // pixel_valid[0]
    output logic                 m_axis_tuser,
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);

    import lpg_pkg::*;

    logic [ADDR_WIDTH-1:0]  base_reg;
    logic                   busy_reg, busy_next;
    logic [X_WIDTH-1:0]     steps_left_reg, steps_left_next;
    logic [X_WIDTH-1:0]     major_pos_reg, major_pos_next;
    logic [X_WIDTH-1:0]     minor_base_reg, minor_base_next;
    logic [X_WIDTH-1:0]     quot_reg, quot_next;
    logic [X_WIDTH-1:0]     rem_reg, rem_next;
    logic [X_WIDTH-1:0]     minor_mag_reg, minor_mag_next;
    logic [X_WIDTH-1:0]     major_delta_reg, major_delta_next;
    logic                   minor_dec_reg, minor_dec_next;
    logic                   steep_reg, steep_next;
    logic [COLOR_WIDTH-1:0] color_reg, color_next;

    logic                   mid_valid_reg, mid_pixel_reg, mid_pixel_next;
    logic                   out_valid_reg, out_pixel_reg, out_last_reg;
    out_data_t              out_data_reg;
    logic                   out_last_next;
    out_data_t              out_data_next;

    logic                   in_accept, mid_advance;
    op_t                    in_op;

    logic [X_WIDTH-1:0]     adx;
    logic [Y_WIDTH-1:0]     ady;
    logic                   start_steep;
    logic [X_WIDTH:0]       rem_sum;
    logic                   rem_wrap;

    logic                   round_up, round_down;
    logic [X_WIDTH-1:0]     minor_now;
    logic [X_WIDTH-1:0]     pix_x;
    logic [Y_WIDTH-1:0]     pix_y;

    assign cfg_ready     = 1'b1;
    assign mid_advance   = mid_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !mid_valid_reg || mid_advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_op         = op_t'(s_axis_tuser);

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_pixel_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = out_data_reg;

    // Line setup and stepping for the request being accepted.
    always_comb
    begin
        adx = (s_axis_tdata.x_first > s_axis_tdata.x_second)
            ? s_axis_tdata.x_first - s_axis_tdata.x_second
            : s_axis_tdata.x_second - s_axis_tdata.x_first;
        ady = (s_axis_tdata.y_first > s_axis_tdata.y_second)
            ? s_axis_tdata.y_first - s_axis_tdata.y_second
            : s_axis_tdata.y_second - s_axis_tdata.y_first;
        start_steep = (adx == '0) || ({1'b0, ady} > adx);

        rem_sum  = {1'b0, rem_reg} + {1'b0, minor_mag_reg};
        rem_wrap = rem_sum >= {1'b0, major_delta_reg};

        busy_next        = busy_reg;
        steps_left_next  = steps_left_reg;
        major_pos_next   = major_pos_reg;
        minor_base_next  = minor_base_reg;
        quot_next        = quot_reg;
        rem_next         = rem_reg;
        minor_mag_next   = minor_mag_reg;
        major_delta_next = major_delta_reg;
        minor_dec_next   = minor_dec_reg;
        steep_next       = steep_reg;
        color_next       = color_reg;
        mid_pixel_next   = 1'b0;

        case (in_op)
            OP_START:
            begin
                color_next     = s_axis_tdata.stroke_color;
                steep_next     = start_steep;
                quot_next      = '0;
                rem_next       = '0;
                mid_pixel_next = 1'b1;
                if (start_steep)
                begin
                    major_delta_next = X_WIDTH'(ady);
                    minor_mag_next   = adx;
                    if (s_axis_tdata.y_first <= s_axis_tdata.y_second)
                    begin
                        major_pos_next  = X_WIDTH'(s_axis_tdata.y_first);
                        minor_base_next = s_axis_tdata.x_first;
                        minor_dec_next  = s_axis_tdata.x_second < s_axis_tdata.x_first;
                    end
                    else
                    begin
                        major_pos_next  = X_WIDTH'(s_axis_tdata.y_second);
                        minor_base_next = s_axis_tdata.x_second;
                        minor_dec_next  = s_axis_tdata.x_first < s_axis_tdata.x_second;
                    end
                end
                else
                begin
                    major_delta_next = adx;
                    minor_mag_next   = X_WIDTH'(ady);
                    if (s_axis_tdata.x_first <= s_axis_tdata.x_second)
                    begin
                        major_pos_next  = s_axis_tdata.x_first;
                        minor_base_next = X_WIDTH'(s_axis_tdata.y_first);
                        minor_dec_next  = s_axis_tdata.y_second < s_axis_tdata.y_first;
                    end
                    else
                    begin
                        major_pos_next  = s_axis_tdata.x_second;
                        minor_base_next = X_WIDTH'(s_axis_tdata.y_second);
                        minor_dec_next  = s_axis_tdata.y_first < s_axis_tdata.y_second;
                    end
                end
                steps_left_next = major_delta_next;
                busy_next       = major_delta_next != '0;
            end
            OP_NEXT:
            begin
                if (busy_reg)
                begin
                    mid_pixel_next  = 1'b1;
                    major_pos_next  = major_pos_reg + X_WIDTH'(1);
                    if (rem_wrap)
                    begin
                        rem_next  = X_WIDTH'(rem_sum - {1'b0, major_delta_reg});
                        quot_next = quot_reg + X_WIDTH'(1);
                    end
                    else
                    begin
                        rem_next = rem_sum[X_WIDTH-1:0];
                    end
                    steps_left_next = steps_left_reg - X_WIDTH'(1);
                    busy_next       = steps_left_next != '0;
                end
            end
            default:
            begin
                mid_pixel_next = 1'b0;
            end
        endcase
    end

    // Rounded minor coordinate and pixel address from the stepped line state.
    always_comb
    begin
        round_up   = {rem_reg, 1'b0} > {1'b0, major_delta_reg};
        round_down = (rem_reg != '0) && ({rem_reg, 1'b0} >= {1'b0, major_delta_reg});
        if (minor_dec_reg)
        begin
            minor_now = minor_base_reg - quot_reg - X_WIDTH'(round_down);
        end
        else
        begin
            minor_now = minor_base_reg + quot_reg + X_WIDTH'(round_up);
        end

        if (steep_reg)
        begin
            pix_x = minor_now;
            pix_y = major_pos_reg[Y_WIDTH-1:0];
        end
        else
        begin
            pix_x = major_pos_reg;
            pix_y = minor_now[Y_WIDTH-1:0];
        end

        out_data_next = '0;
        out_last_next = 1'b0;
        if (mid_pixel_reg)
        begin
            out_data_next.pixel_x       = pix_x;
            out_data_next.pixel_y       = pix_y;
            out_data_next.pixel_address = base_reg
                                        + (ADDR_WIDTH'(pix_y) << ROW_SHIFT)
                                        + (ADDR_WIDTH'(pix_x) << PIXEL_SHIFT);
            out_data_next.pixel_color   = color_reg;
            out_last_next               = steps_left_reg == '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg        <= BASE_RESET;
            busy_reg        <= 1'b0;
            steps_left_reg  <= '0;
            major_pos_reg   <= '0;
            minor_base_reg  <= '0;
            quot_reg        <= '0;
            rem_reg         <= '0;
            minor_mag_reg   <= '0;
            major_delta_reg <= '0;
            minor_dec_reg   <= 1'b0;
            steep_reg       <= 1'b0;
            color_reg       <= '0;
            mid_valid_reg   <= 1'b0;
            mid_pixel_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_pixel_reg   <= 1'b0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                base_reg <= cfg_data;
            end

            if (in_accept)
            begin
                busy_reg        <= busy_next;
                steps_left_reg  <= steps_left_next;
                major_pos_reg   <= major_pos_next;
                minor_base_reg  <= minor_base_next;
                quot_reg        <= quot_next;
                rem_reg         <= rem_next;
                minor_mag_reg   <= minor_mag_next;
                major_delta_reg <= major_delta_next;
                minor_dec_reg   <= minor_dec_next;
                steep_reg       <= steep_next;
                color_reg       <= color_next;
                mid_pixel_reg   <= mid_pixel_next;
                mid_valid_reg   <= 1'b1;
            end
            else if (mid_advance)
            begin
                mid_valid_reg <= 1'b0;
            end

            if (mid_advance)
            begin
                out_valid_reg <= 1'b1;
                out_pixel_reg <= mid_pixel_reg;
                out_last_reg  <= out_last_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `include "line_pixel_generator_top_assert.svh"

    `LPG_ASSERT_SAME(busy_has_steps, busy_reg, steps_left_reg != '0)
    `LPG_ASSERT_SAME(remainder_below_delta, busy_reg, rem_reg < major_delta_reg)
    `LPG_ASSERT_SAME(idle_result_is_empty, m_axis_tvalid && !m_axis_tuser,
                     (m_axis_tdata == '0) && !m_axis_tlast)
    `LPG_ASSERT_SAME(no_overrun_when_stalled,
                     mid_valid_reg && m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

>>> sim/line_pixel_generator_top_tb.sv
// Self-checking testbench for the line pixel generator: directed table, random lines, backpressure.
`timescale 1ns / 1ps

module line_pixel_generator_top_tb;
    import lpg_pkg::*;

    localparam int unsigned ROW_SHIFT   = 10;
    localparam int unsigned PIXEL_SHIFT = 1;
    localparam int          ROWS        = 25;
    localparam logic        TYPED       = 1'b1;
    localparam logic        PREDICTED   = 1'b0;

    typedef struct packed
    {
        logic        valid;
        logic [8:0]  x;
        logic [7:0]  y;
        logic [31:0] addr;
        logic [15:0] color;
        logic        last;
    } pixel_t;

    typedef struct packed
    {
        op_t         op;
        logic [8:0]  x1;
        logic [7:0]  y1;
        logic [8:0]  x2;
        logic [7:0]  y2;
        logic [15:0] color;
        logic        typed;
        pixel_t      result;
    } stim_row_t;

    localparam pixel_t PIX_IDLE   = '0;
    localparam pixel_t PIX_ORIGIN = {1'b1, 9'd0, 8'd0, 32'hC800_0000, 16'hFFFF, 1'b1};
    localparam pixel_t PIX_CORNER = {1'b1, 9'd511, 8'd255, 32'hC803_FFFE, 16'h0000, 1'b1};

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    in_data_t    s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    out_data_t   m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data      = '0;

    logic [31:0] base_reg      = BASE_RESET;
    logic        line_busy     = 1'b0;
    logic [9:0]  steps_to_go   = '0;
    logic [8:0]  major_pos     = '0;
    logic [8:0]  minor_start   = '0;
    logic [8:0]  off_q         = '0;
    logic [9:0]  off_r         = '0;
    logic [8:0]  minor_step    = '0;
    logic [8:0]  major_len     = '0;
    logic        minor_down    = 1'b0;
    logic        steep         = 1'b0;
    logic [15:0] color_reg     = '0;

    pixel_t      pixel_q [$];
    stim_row_t   directed_rows [0:ROWS-1];
    int          error_count   = 0;
    int          pixel_count   = 0;
    int          sent_count    = 0;
    int          src_gap_max   = 4;
    int          sink_gap_max  = 4;

    line_pixel_generator_top #(
        .ROW_SHIFT   (ROW_SHIFT),
        .PIXEL_SHIFT (PIXEL_SHIFT)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [8:0] minor_coord();
        logic [10:0] twice_r;
        twice_r = {off_r, 1'b0};
        if (!minor_down)
            return minor_start + off_q + ((twice_r > major_len) ? 9'd1 : 9'd0);
        return minor_start - off_q - (((off_r != 0) && (twice_r >= major_len)) ? 9'd1 : 9'd0);
    endfunction

    function automatic pixel_t form_pixel();
        pixel_t     p;
        logic [8:0] minor;
        minor = minor_coord();
        p.valid = 1'b1;
        if (steep)
        begin
            p.x = minor;
            p.y = major_pos[7:0];
        end
        else
        begin
            p.x = major_pos;
            p.y = minor[7:0];
        end
        p.addr  = base_reg + ({24'd0, p.y} << ROW_SHIFT) + ({23'd0, p.x} << PIXEL_SHIFT);
        p.color = color_reg;
        p.last  = (steps_to_go == 0);
        return p;
    endfunction

    function automatic in_data_t random_data();
        in_data_t r;
        r = '0;
        r.x_first      = X_WIDTH'($urandom);
        r.y_first      = Y_WIDTH'($urandom);
        r.x_second     = X_WIDTH'($urandom);
        r.y_second     = Y_WIDTH'($urandom);
        r.stroke_color = COLOR_WIDTH'($urandom);
        return r;
    endfunction

    task automatic rasterize_step(input op_t op, input in_data_t d, output pixel_t p);
        logic [8:0] adx;
        logic [8:0] ady;
        logic [8:0] end_minor;
        if (op == OP_START)
        begin
            adx = (d.x_first > d.x_second) ? d.x_first - d.x_second : d.x_second - d.x_first;
            ady = {1'b0, (d.y_first > d.y_second) ? d.y_first - d.y_second
                                                  : d.y_second - d.y_first};
            color_reg = d.stroke_color;
            steep = (adx == 0) || (ady > adx);
            if (steep)
            begin
                if (d.y_first <= d.y_second)
                begin
                    major_pos   = {1'b0, d.y_first};
                    minor_start = d.x_first;
                    end_minor   = d.x_second;
                end
                else
                begin
                    major_pos   = {1'b0, d.y_second};
                    minor_start = d.x_second;
                    end_minor   = d.x_first;
                end
                major_len  = ady;
                minor_step = adx;
            end
            else
            begin
                if (d.x_first <= d.x_second)
                begin
                    major_pos   = d.x_first;
                    minor_start = {1'b0, d.y_first};
                    end_minor   = {1'b0, d.y_second};
                end
                else
                begin
                    major_pos   = d.x_second;
                    minor_start = {1'b0, d.y_second};
                    end_minor   = {1'b0, d.y_first};
                end
                major_len  = adx;
                minor_step = ady;
            end
            minor_down  = (end_minor < minor_start);
            off_q       = '0;
            off_r       = '0;
            steps_to_go = {1'b0, major_len};
            line_busy   = (steps_to_go != 0);
            p = form_pixel();
        end
        else if (!line_busy)
        begin
            p = PIX_IDLE;
        end
        else
        begin
            major_pos = major_pos + 9'd1;
            off_r     = off_r + {1'b0, minor_step};
            if (off_r >= {1'b0, major_len})
            begin
                off_r = off_r - {1'b0, major_len};
                off_q = off_q + 9'd1;
            end
            steps_to_go = steps_to_go - 10'd1;
            if (steps_to_go == 0)
                line_busy = 1'b0;
            p = form_pixel();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= 40)
            $display("mismatch on %s at pixel %0d: got %h, expected %h",
                     what, pixel_count, got, want);
    endtask

    task automatic send_request(input op_t op, input in_data_t d, input logic typed,
                                input pixel_t typed_px);
        int     gap;
        pixel_t predicted;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        d.pad = '0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);
        rasterize_step(op, d, predicted);
        pixel_q.push_back(typed ? typed_px : predicted);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pixel_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        base_reg = value;
    endtask

    task automatic random_line();
        int       kind;
        int       reach;
        int       x1, y1, x2, y2;
        int       adx, ady, span, walk;
        in_data_t d;
        d = '0;
        kind = $urandom_range(99, 0);
        if (kind < 12)
        begin
            d = random_data();
            send_request(op_t'($urandom_range(1, 0)), d, PREDICTED, PIX_IDLE);
            return;
        end
        reach = (kind < 80) ? 15 : ((kind < 92) ? 64 : 511);
        x1 = $urandom_range(511, 0);
        y1 = $urandom_range(255, 0);
        x2 = $urandom_range((x1 + reach < 511) ? x1 + reach : 511,
                            (x1 > reach) ? x1 - reach : 0);
        y2 = $urandom_range((y1 + reach < 255) ? y1 + reach : 255,
                            (y1 > reach) ? y1 - reach : 0);
        adx  = (x1 > x2) ? x1 - x2 : x2 - x1;
        ady  = (y1 > y2) ? y1 - y2 : y2 - y1;
        span = (adx > ady) ? adx : ady;
        case ($urandom_range(9, 0))
            0:       walk = $urandom_range(span, 0);
            1:       walk = span + $urandom_range(3, 1);
            default: walk = span;
        endcase
        if (reach == 511 && walk > 40)
            walk = 40;
        d.x_first      = X_WIDTH'(x1);
        d.y_first      = Y_WIDTH'(y1);
        d.x_second     = X_WIDTH'(x2);
        d.y_second     = Y_WIDTH'(y2);
        d.stroke_color = COLOR_WIDTH'($urandom);
        send_request(OP_START, d, PREDICTED, PIX_IDLE);
        repeat (walk)
            send_request(OP_NEXT, random_data(), PREDICTED, PIX_IDLE);
    endtask

    initial
    begin
        directed_rows[0]  = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, TYPED, PIX_IDLE};
        directed_rows[1]  = {OP_START, 9'd0,   8'd0,   9'd0,   8'd0,   16'hFFFF, TYPED,
                             PIX_ORIGIN};
        directed_rows[2]  = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, TYPED, PIX_IDLE};
        directed_rows[3]  = {OP_START, 9'd511, 8'd255, 9'd511, 8'd255, 16'h0000, TYPED,
                             PIX_CORNER};
        directed_rows[4]  = {OP_START, 9'd0,   8'd10,  9'd4,   8'd10,  16'h1234, PREDICTED,
                             PIX_IDLE};
        for (int i = 5; i < 9; i++)
            directed_rows[i] = {OP_NEXT, 9'd0, 8'd0, 9'd0, 8'd0, 16'h0000, PREDICTED, PIX_IDLE};
        directed_rows[9]  = {OP_START, 9'd7,   8'd0,   9'd7,   8'd3,   16'hF800, PREDICTED,
                             PIX_IDLE};
        for (int i = 10; i < 13; i++)
            directed_rows[i] = {OP_NEXT, 9'd0, 8'd0, 9'd0, 8'd0, 16'h0000, PREDICTED, PIX_IDLE};
        directed_rows[13] = {OP_START, 9'd10,  8'd0,   9'd8,   8'd5,   16'h07E0, PREDICTED,
                             PIX_IDLE};
        directed_rows[14] = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, PREDICTED,
                             PIX_IDLE};
        directed_rows[15] = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, PREDICTED,
                             PIX_IDLE};
        directed_rows[16] = {OP_START, 9'd2,   8'd1,   9'd0,   8'd0,   16'h001F, PREDICTED,
                             PIX_IDLE};
        directed_rows[17] = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, PREDICTED,
                             PIX_IDLE};
        directed_rows[18] = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, PREDICTED,
                             PIX_IDLE};
        directed_rows[19] = {OP_START, 9'd0,   8'd1,   9'd2,   8'd0,   16'hAAAA, PREDICTED,
                             PIX_IDLE};
        directed_rows[20] = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, PREDICTED,
                             PIX_IDLE};
        directed_rows[21] = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, PREDICTED,
                             PIX_IDLE};
        directed_rows[22] = {OP_START, 9'd511, 8'd0,   9'd0,   8'd255, 16'h5555, PREDICTED,
                             PIX_IDLE};
        directed_rows[23] = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, PREDICTED,
                             PIX_IDLE};
        directed_rows[24] = {OP_NEXT,  9'd0,   8'd0,   9'd0,   8'd0,   16'h0000, PREDICTED,
                             PIX_IDLE};
    end

    initial
    begin
        in_data_t d;
        int       phase_end;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < ROWS; i++)
        begin
            d = '0;
            d.x_first      = directed_rows[i].x1;
            d.y_first      = directed_rows[i].y1;
            d.x_second     = directed_rows[i].x2;
            d.y_second     = directed_rows[i].y2;
            d.stroke_color = directed_rows[i].color;
            send_request(directed_rows[i].op, d, directed_rows[i].typed, directed_rows[i].result);
        end
        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            case (phase)
                0:       write_base(32'h0000_0000);
                1:       write_base(32'hFFFF_FFFF);
                default: write_base($urandom);
            endcase
            src_gap_max  = ($urandom_range(2, 0) == 0) ? 0 : 4;
            sink_gap_max = ($urandom_range(2, 0) == 0) ? 0 : 4;
            phase_end = sent_count + 100;
            while (sent_count < phase_end)
                random_line();
        end
        wait_drained();
        repeat (8) @(posedge clk);
        if (pixel_q.size() != 0)
            report_mismatch("results still outstanding", pixel_q.size(), 0);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        int     gap;
        pixel_t want;
        wait (rst_n);
        forever
        begin
            gap = $urandom_range(sink_gap_max, 0);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            pixel_count++;
            if (pixel_q.size() == 0)
            begin
                report_mismatch("unexpected pixel", m_axis_tdata.pixel_address, 0);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (m_axis_tuser !== want.valid)
                    report_mismatch("pixel_valid", 32'(m_axis_tuser), 32'(want.valid));
                if (m_axis_tdata.pixel_x !== want.x)
                    report_mismatch("pixel_x", 32'(m_axis_tdata.pixel_x), 32'(want.x));
                if (m_axis_tdata.pixel_y !== want.y)
                    report_mismatch("pixel_y", 32'(m_axis_tdata.pixel_y), 32'(want.y));
                if (m_axis_tdata.pixel_address !== want.addr)
                    report_mismatch("pixel_address", m_axis_tdata.pixel_address, want.addr);
                if (m_axis_tdata.pixel_color !== want.color)
                    report_mismatch("pixel_color", 32'(m_axis_tdata.pixel_color),
                                    32'(want.color));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_pixel", 32'(m_axis_tlast), 32'(want.last));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
